>>> rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg: shared definitions for the quadratic root solver
// Default widths, root count codes and the status record that travels
// with each request through the divider cells.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEFF_BITS    = 16;
  localparam int FRACTION_BITS = 16;
  localparam int OUT_BITS      = 40;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  typedef struct packed {
    logic [1:0] count;
    logic       neg_p;
    logic       neg_m;
  } qrs_meta_t;

endpackage

>>> rtl/qrs_ifs.sv
// ----------------------------------------------------------------------------
// qrs channel interfaces
// Valid/ready channels for coefficient requests and root results.
// ----------------------------------------------------------------------------
interface qrs_in_if #(parameter int COEFF_BITS = qrs_pkg::COEFF_BITS);
  logic                         valid;
  logic                         ready;
  logic signed [COEFF_BITS-1:0] coeff_a;
  logic signed [COEFF_BITS-1:0] coeff_b;
  logic signed [COEFF_BITS-1:0] coeff_c;
  modport source (output valid, coeff_a, coeff_b, coeff_c, input ready);
  modport sink   (input valid, coeff_a, coeff_b, coeff_c, output ready);
endinterface

interface qrs_out_if;
  logic                               valid;
  logic                               ready;
  logic        [1:0]                  root_count;
  logic signed [qrs_pkg::OUT_BITS-1:0] root_plus;
  logic signed [qrs_pkg::OUT_BITS-1:0] root_minus;
  modport source (output valid, root_count, root_plus, root_minus, input ready);
  modport sink   (input valid, root_count, root_plus, root_minus, output ready);
endinterface

>>> rtl/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell: one digit step of the integer square root
// Brings in two radicand bits, tries the next root bit and hands the
// partial root and remainder to the next cell.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
  parameter int H  = 17,
  parameter int SW = 37
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [H+1:0]    in_rem,
  input  logic [H-1:0]    in_root,
  input  logic [2*H-1:0]  in_d,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [H+1:0]    out_rem,
  output logic [H-1:0]    out_root,
  output logic [2*H-1:0]  out_d,
  output logic [SW-1:0]   out_side
);

  logic           valid_r;
  logic [H+1:0]   rem_r, rem_nxt;
  logic [H-1:0]   root_r, root_nxt;
  logic [2*H-1:0] d_r, d_nxt;
  logic [SW-1:0]  side_r;
  logic [H+1:0]   shifted, trial;
  logic           ge;

  always_comb begin
    shifted  = {in_rem[H-1:0], in_d[2*H-1:2*H-2]};
    trial    = {in_root, 2'b01};
    ge       = shifted >= trial;
    rem_nxt  = ge ? (shifted - trial) : shifted;
    root_nxt = {in_root[H-2:0], ge};
    d_nxt    = {in_d[2*H-3:0], 2'b00};
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      d_r    <= d_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_d     = d_r;
  assign out_side  = side_r;

endmodule

>>> rtl/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell: one restoring division step for both root branches
// Each lane shifts one dividend bit into its remainder and shifts the
// quotient bit into the low end of the dividend word.
// ----------------------------------------------------------------------------
module qrs_div_cell #(
  parameter int DB = 17,
  parameter int NB = 34
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  qrs_pkg::qrs_meta_t in_meta,
  input  logic [DB-1:0]      in_den,
  input  logic [DB-1:0]      in_rem_p,
  input  logic [DB-1:0]      in_rem_m,
  input  logic [NB-1:0]      in_nq_p,
  input  logic [NB-1:0]      in_nq_m,
  output logic               out_valid,
  input  logic               out_ready,
  output qrs_pkg::qrs_meta_t out_meta,
  output logic [DB-1:0]      out_den,
  output logic [DB-1:0]      out_rem_p,
  output logic [DB-1:0]      out_rem_m,
  output logic [NB-1:0]      out_nq_p,
  output logic [NB-1:0]      out_nq_m
);

  logic               valid_r;
  qrs_pkg::qrs_meta_t meta_r;
  logic [DB-1:0]      den_r;
  logic [DB-1:0]      rem_p_r, rem_p_nxt, rem_m_r, rem_m_nxt;
  logic [NB-1:0]      nq_p_r, nq_p_nxt, nq_m_r, nq_m_nxt;
  logic [DB:0]        sh_p, sh_m, sub_p, sub_m;
  logic               ge_p, ge_m;

  always_comb begin
    sh_p      = {in_rem_p, in_nq_p[NB-1]};
    sh_m      = {in_rem_m, in_nq_m[NB-1]};
    ge_p      = sh_p >= {1'b0, in_den};
    ge_m      = sh_m >= {1'b0, in_den};
    sub_p     = ge_p ? (sh_p - {1'b0, in_den}) : sh_p;
    sub_m     = ge_m ? (sh_m - {1'b0, in_den}) : sh_m;
    rem_p_nxt = sub_p[DB-1:0];
    rem_m_nxt = sub_m[DB-1:0];
    nq_p_nxt  = {in_nq_p[NB-2:0], ge_p};
    nq_m_nxt  = {in_nq_m[NB-2:0], ge_m};
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      meta_r  <= in_meta;
      den_r   <= in_den;
      rem_p_r <= rem_p_nxt;
      rem_m_r <= rem_m_nxt;
      nq_p_r  <= nq_p_nxt;
      nq_m_r  <= nq_m_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_meta  = meta_r;
  assign out_den   = den_r;
  assign out_rem_p = rem_p_r;
  assign out_rem_m = rem_m_r;
  assign out_nq_p  = nq_p_r;
  assign out_nq_m  = nq_m_r;

endmodule

>>> rtl/quadratic_root_solver_top.sv
// One square root cell per root bit and one divider cell per quotient bit.
// Throughput: one request per cycle while the output is not stalled; every stage
// takes a new request each cycle unless the stage after it is full and held.
// Each stage has its own valid bit, so stalls are absorbed stage by stage.
// Reset (rst_n low, synchronous) clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// quadratic_root_solver_top: pipelined quadratic root solver
// Multiplies, classifies, takes the floored square root of the
// discriminant and divides both branches in fixed point with saturation.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top #(
  parameter int COEFF_BITS    = qrs_pkg::COEFF_BITS,
  parameter int FRACTION_BITS = qrs_pkg::FRACTION_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  qrs_in_if.sink      in_chan,
  qrs_out_if.source   out_chan
);

  localparam int B  = COEFF_BITS;
  localparam int H  = B + 1;
  localparam int DW = 2 * H;
  localparam int SW = 2 * (B + 1) + 3;
  localparam int DB = B + 1;
  localparam int MW = B + 2;
  localparam int NB = MW + FRACTION_BITS;
  localparam int OW = qrs_pkg::OUT_BITS;
  localparam int QW = ((NB > OW) ? NB : OW) + 1;

  // Stage 1: input register.
  logic                v1_r, rdy1;
  logic signed [B-1:0] a1_r, b1_r, c1_r;
  // Stage 2: products.
  logic                  v2_r, rdy2;
  logic signed [B-1:0]   a2_r, b2_r, c2_r;
  logic signed [2*B-1:0] bb2_r, ac2_r;
  // Stage 3: classification, feeds the square root chain.
  logic           v3_r, rdy3;
  logic [DW-1:0]  d3_r, d3_nxt;
  logic [SW-1:0]  side3_r, side3_nxt;

  logic signed [DW:0] bbx, acx, disc;
  logic signed [B:0]  negb, negc, b_ext, a_dbl, nbase3, den3;
  logic [1:0]         cnt3;
  logic               use_s3;

  assign rdy1 = !v1_r || rdy2;
  assign rdy2 = !v2_r || rdy3;
  assign in_chan.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_chan.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      a1_r <= in_chan.coeff_a;
      b1_r <= in_chan.coeff_b;
      c1_r <= in_chan.coeff_c;
    end
    if (rdy2) begin
      a2_r  <= a1_r;
      b2_r  <= b1_r;
      c2_r  <= c1_r;
      bb2_r <= b1_r * b1_r;
      ac2_r <= a1_r * c1_r;
    end
    if (rdy3) begin
      d3_r    <= d3_nxt;
      side3_r <= side3_nxt;
    end
  end

  always_comb begin
    bbx    = {{3{bb2_r[2*B-1]}}, bb2_r};
    acx    = {{3{ac2_r[2*B-1]}}, ac2_r};
    disc   = bbx - (acx <<< 2);
    negb   = -{b2_r[B-1], b2_r};
    negc   = -{c2_r[B-1], c2_r};
    b_ext  = {b2_r[B-1], b2_r};
    a_dbl  = {a2_r, 1'b0};
    d3_nxt = '0;
    use_s3 = 1'b0;
    nbase3 = '0;
    den3   = '0;
    if (a2_r == '0) begin
      if (b2_r == '0) begin
        cnt3 = (c2_r == '0) ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
      end else begin
        // Linear equation: root is -c / b.
        cnt3   = qrs_pkg::CNT_ONE;
        nbase3 = negc;
        den3   = b_ext;
      end
    end else if (disc[DW]) begin
      cnt3 = qrs_pkg::CNT_NONE;
    end else begin
      cnt3   = (disc == '0) ? qrs_pkg::CNT_ONE : qrs_pkg::CNT_TWO;
      use_s3 = 1'b1;
      nbase3 = negb;
      den3   = a_dbl;
      d3_nxt = disc[DW-1:0];
    end
    side3_nxt = {cnt3, use_s3, nbase3, den3};
  end

  // Square root chain.
  logic          sq_valid [0:H];
  logic          sq_ready [0:H];
  logic [H+1:0]  sq_rem   [0:H];
  logic [H-1:0]  sq_root  [0:H];
  logic [DW-1:0] sq_d     [0:H];
  logic [SW-1:0] sq_side  [0:H];

  assign sq_valid[0] = v3_r;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_d[0]     = d3_r;
  assign sq_side[0]  = side3_r;
  assign rdy3        = !v3_r || sq_ready[0];

  genvar gi;
  generate
    for (gi = 0; gi < H; gi++) begin : g_sqrt
      qrs_sqrt_cell #(.H(H), .SW(SW)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid[gi]),
        .in_ready  (sq_ready[gi]),
        .in_rem    (sq_rem[gi]),
        .in_root   (sq_root[gi]),
        .in_d      (sq_d[gi]),
        .in_side   (sq_side[gi]),
        .out_valid (sq_valid[gi+1]),
        .out_ready (sq_ready[gi+1]),
        .out_rem   (sq_rem[gi+1]),
        .out_root  (sq_root[gi+1]),
        .out_d     (sq_d[gi+1]),
        .out_side  (sq_side[gi+1])
      );
    end
  endgenerate

  // Stage 4: numerators and signs, feeds the divider chain.
  logic               v4_r, rdy4;
  qrs_pkg::qrs_meta_t meta4_r, meta4_nxt;
  logic [DB-1:0]      den4_r, den4_nxt;
  logic [NB-1:0]      np4_r, np4_nxt, nm4_r, nm4_nxt;

  logic [1:0]          cnt4;
  logic                use_s4;
  logic signed [B:0]   nbase4, den4s, den4abs;
  logic signed [B+2:0] nbx, sx, np, nm, npabs, nmabs;

  always_comb begin
    {cnt4, use_s4, nbase4, den4s} = sq_side[H];
    nbx       = {{2{nbase4[B]}}, nbase4};
    sx        = use_s4 ? {2'b00, sq_root[H]} : '0;
    np        = nbx + sx;
    nm        = nbx - sx;
    npabs     = np[B+2] ? -np : np;
    nmabs     = nm[B+2] ? -nm : nm;
    den4abs   = den4s[B] ? -den4s : den4s;
    den4_nxt  = den4abs;
    np4_nxt   = NB'(npabs[MW-1:0]) << FRACTION_BITS;
    nm4_nxt   = NB'(nmabs[MW-1:0]) << FRACTION_BITS;
    meta4_nxt.count = cnt4;
    meta4_nxt.neg_p = np[B+2] ^ den4s[B];
    meta4_nxt.neg_m = nm[B+2] ^ den4s[B];
  end

  assign sq_ready[H] = rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= sq_valid[H];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      meta4_r <= meta4_nxt;
      den4_r  <= den4_nxt;
      np4_r   <= np4_nxt;
      nm4_r   <= nm4_nxt;
    end
  end

  // Divider chain.
  logic               dv_valid [0:NB];
  logic               dv_ready [0:NB];
  qrs_pkg::qrs_meta_t dv_meta  [0:NB];
  logic [DB-1:0]      dv_den   [0:NB];
  logic [DB-1:0]      dv_rem_p [0:NB];
  logic [DB-1:0]      dv_rem_m [0:NB];
  logic [NB-1:0]      dv_nq_p  [0:NB];
  logic [NB-1:0]      dv_nq_m  [0:NB];

  assign dv_valid[0] = v4_r;
  assign dv_meta[0]  = meta4_r;
  assign dv_den[0]   = den4_r;
  assign dv_rem_p[0] = '0;
  assign dv_rem_m[0] = '0;
  assign dv_nq_p[0]  = np4_r;
  assign dv_nq_m[0]  = nm4_r;
  assign rdy4        = !v4_r || dv_ready[0];

  genvar gj;
  generate
    for (gj = 0; gj < NB; gj++) begin : g_div
      qrs_div_cell #(.DB(DB), .NB(NB)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid[gj]),
        .in_ready  (dv_ready[gj]),
        .in_meta   (dv_meta[gj]),
        .in_den    (dv_den[gj]),
        .in_rem_p  (dv_rem_p[gj]),
        .in_rem_m  (dv_rem_m[gj]),
        .in_nq_p   (dv_nq_p[gj]),
        .in_nq_m   (dv_nq_m[gj]),
        .out_valid (dv_valid[gj+1]),
        .out_ready (dv_ready[gj+1]),
        .out_meta  (dv_meta[gj+1]),
        .out_den   (dv_den[gj+1]),
        .out_rem_p (dv_rem_p[gj+1]),
        .out_rem_m (dv_rem_m[gj+1]),
        .out_nq_p  (dv_nq_p[gj+1]),
        .out_nq_m  (dv_nq_m[gj+1])
      );
    end
  endgenerate

  // Stage 5: saturation, sign and output register.
  logic          ov_r, rdy5;
  logic [1:0]    ocnt_r;
  logic [OW-1:0] op_r, om_r, op_nxt, om_nxt;

  localparam logic [QW-1:0] LIM = QW'({1'b0, {(OW-1){1'b1}}});
  localparam logic [QW-1:0] LIM_NEG = LIM + QW'(1);

  function automatic logic [OW-1:0] qrs_sat(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0] t;
    begin
      if (neg) begin
        t = (q > LIM_NEG) ? LIM_NEG : q;
        t = -t;
      end else begin
        t = (q > LIM) ? LIM : q;
      end
      return t[OW-1:0];
    end
  endfunction

  logic zero_out;

  always_comb begin
    zero_out = (dv_meta[NB].count == qrs_pkg::CNT_NONE) ||
               (dv_meta[NB].count == qrs_pkg::CNT_INF);
    op_nxt = zero_out ? '0 : qrs_sat(QW'(dv_nq_p[NB]), dv_meta[NB].neg_p);
    om_nxt = zero_out ? '0 : qrs_sat(QW'(dv_nq_m[NB]), dv_meta[NB].neg_m);
  end

  assign rdy5         = !ov_r || out_chan.ready;
  assign dv_ready[NB] = rdy5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (rdy5) begin
      ov_r <= dv_valid[NB];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      ocnt_r <= dv_meta[NB].count;
      op_r   <= op_nxt;
      om_r   <= om_nxt;
    end
  end

  assign out_chan.valid      = ov_r;
  assign out_chan.root_count = ocnt_r;
  assign out_chan.root_plus  = op_r;
  assign out_chan.root_minus = om_r;

endmodule
